/* rtl/core/palette_slot_lru_manager_assert.svh */
// Assertion macros for the palette slot manager RTL.
// Both macros clock on the rising edge of the given clock and are disabled while reset is low.
`ifndef PALETTE_SLOT_LRU_MANAGER_ASSERT_SVH
`define PALETTE_SLOT_LRU_MANAGER_ASSERT_SVH

`ifndef SYNTHESIS

`define PLSM_ASSERT(name, clk, rst_n, prop) \
  name: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("plsm assertion failed");

`define PLSM_ASSERT_NEVER(name, clk, rst_n, expr) \
  name: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
    else $error("plsm forbidden condition seen");

`else

`define PLSM_ASSERT(name, clk, rst_n, prop)

`define PLSM_ASSERT_NEVER(name, clk, rst_n, expr)

`endif

`endif

/* rtl/core/plsm_pkg.sv */
package plsm_pkg;

  // Default number of palette slots
  localparam int SLOT_COUNT_DEF = 16;

  // Fixed field widths
  localparam int TAG_W   = 8;
  localparam int REFS_W  = 8;
  localparam int AGE_W   = 8;
  localparam int BIT_W   = 3;
  localparam int COLOR_W = 16;
  localparam int SLOT_W  = 4;
  localparam int NCOLORS = 4;

  typedef enum logic [1:0] {
    ACT_TICK    = 2'd0,
    ACT_ACQUIRE = 2'd1,
    ACT_RELEASE = 2'd2,
    ACT_LOOKUP  = 2'd3
  } action_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EVAL,
    ST_SCAN,
    ST_FIN
  } state_e;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic             capture;
    logic             commit;
    logic             scan_init;
    logic             scan_step;
    logic             evict;
    logic [BIT_W-1:0] bit_sel;
  } dp_cmd_t;

  // Status from the datapath to the controller
  typedef struct packed {
    logic need_scan;
    logic idle_any;
    logic out_free;
  } dp_status_t;

endpackage

/* rtl/core/plsm_ctrl.sv */
`include "palette_slot_lru_manager_assert.svh"

module plsm_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  plsm_pkg::dp_status_t status_i,
  output plsm_pkg::dp_cmd_t    cmd_o
);
  import plsm_pkg::*;

  state_e           state_q, state_d;
  logic [BIT_W-1:0] bit_q, bit_d;

  // State and search bit registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      bit_q   <= '0;
    end else begin
      state_q <= state_d;
      bit_q   <= bit_d;
    end
  end

  // Next state and datapath commands
  always_comb begin
    state_d       = state_q;
    bit_d         = bit_q;
    cmd_o         = '0;
    cmd_o.bit_sel = bit_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.capture = 1'b1;
          state_d       = ST_EVAL;
        end
      end
      ST_EVAL: begin
        if (status_i.need_scan && status_i.idle_any) begin
          // start the age search from the top bit
          cmd_o.scan_init = 1'b1;
          bit_d           = BIT_W'(AGE_W - 1);
          state_d         = ST_SCAN;
        end else if (status_i.out_free) begin
          cmd_o.commit = 1'b1;
          state_d      = ST_IDLE;
        end
      end
      ST_SCAN: begin
        cmd_o.scan_step = 1'b1;
        if (bit_q == '0) begin
          state_d = ST_FIN;
        end else begin
          bit_d = bit_q - BIT_W'(1);
        end
      end
      ST_FIN: begin
        if (status_i.out_free) begin
          cmd_o.evict = 1'b1;
          state_d     = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  assign in_stall_o = (state_q != ST_IDLE);

  `PLSM_ASSERT(a_capture_to_eval, clk_i, rst_ni, (state_q == ST_IDLE && in_valid_i) |=> (state_q == ST_EVAL))
  `PLSM_ASSERT(a_scan_ends_in_fin, clk_i, rst_ni, (state_q == ST_SCAN && bit_q == '0) |=> (state_q == ST_FIN))
  `PLSM_ASSERT(a_result_needs_room, clk_i, rst_ni, (cmd_o.commit || cmd_o.evict) |-> status_i.out_free)
  `PLSM_ASSERT_NEVER(a_scan_without_idle, clk_i, rst_ni, cmd_o.scan_init && !status_i.idle_any)

endmodule

/* rtl/core/plsm_dp.sv */
module plsm_dp #(
  parameter int SLOT_COUNT = plsm_pkg::SLOT_COUNT_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  plsm_pkg::dp_cmd_t             cmd_i,
  output plsm_pkg::dp_status_t          status_o,
  input  logic [1:0]                    action_i,
  input  logic [plsm_pkg::TAG_W-1:0]    type_id_i,
  input  logic [plsm_pkg::COLOR_W-1:0]  in_color0_i,
  input  logic [plsm_pkg::COLOR_W-1:0]  in_color1_i,
  input  logic [plsm_pkg::COLOR_W-1:0]  in_color2_i,
  input  logic [plsm_pkg::COLOR_W-1:0]  in_color3_i,
  input  logic                          out_stall_i,
  output logic                          out_valid_o,
  output logic [plsm_pkg::SLOT_W-1:0]   slot_o,
  output logic                          slot_ok_o,
  output logic                          upload_o,
  output logic [plsm_pkg::COLOR_W-1:0]  up_color0_o,
  output logic [plsm_pkg::COLOR_W-1:0]  up_color1_o,
  output logic [plsm_pkg::COLOR_W-1:0]  up_color2_o,
  output logic [plsm_pkg::COLOR_W-1:0]  up_color3_o
);
  import plsm_pkg::*;

  localparam int N     = SLOT_COUNT;
  localparam int IDX_W = $clog2(SLOT_COUNT);

  // Slot cells
  logic [N-1:0]        valid_q;
  logic [TAG_W-1:0]    type_q  [N];
  logic [REFS_W-1:0]   refs_q  [N];
  logic [AGE_W-1:0]    stamp_q [N];
  logic [AGE_W-1:0]    frame_q;

  // Captured transaction
  action_e             act_q;
  logic [TAG_W-1:0]    tag_q;
  logic [COLOR_W-1:0]  col_q [NCOLORS];

  // Candidate mask of the age search
  logic [N-1:0]        mask_q;

  // Result register
  logic                out_valid_q;
  logic [SLOT_W-1:0]   slot_q;
  logic                ok_q;
  logic                up_q;
  logic [COLOR_W-1:0]  ucol_q [NCOLORS];

  logic [N-1:0]        match_vec, free_vec, idle_vec, agebit_vec, narrow_vec;
  logic [N-1:0]        hit_oh, free_oh, mask_oh;
  logic [N-1:0]        inc_oh, dec_oh, load_oh;
  logic [IDX_W-1:0]    hit_idx, free_idx, mask_idx;
  logic [AGE_W-1:0]    age [N];
  logic                hit, free_any, out_free;
  logic                res_we, res_ok, res_up;
  logic [IDX_W-1:0]    res_idx;

  // Capture the accepted transaction
  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      act_q    <= action_e'(action_i);
      tag_q    <= type_id_i;
      col_q[0] <= in_color0_i;
      col_q[1] <= in_color1_i;
      col_q[2] <= in_color2_i;
      col_q[3] <= in_color3_i;
    end
  end

  // Per-slot compare, idle check and age bit
  always_comb begin
    for (int i = 0; i < N; i++) begin
      match_vec[i]  = valid_q[i] && (type_q[i] == tag_q);
      idle_vec[i]   = valid_q[i] && (refs_q[i] == '0);
      age[i]        = frame_q - stamp_q[i];
      agebit_vec[i] = age[i][cmd_i.bit_sel];
    end
  end

  assign free_vec   = ~valid_q;
  assign narrow_vec = mask_q & agebit_vec;
  assign hit        = |match_vec;
  assign free_any   = |free_vec;

  // Lowest set bit as one-hot
  assign hit_oh  = match_vec & (~match_vec + N'(1));
  assign free_oh = free_vec & (~free_vec + N'(1));
  assign mask_oh = mask_q & (~mask_q + N'(1));

  // Lowest set bit as index
  always_comb begin
    hit_idx  = '0;
    free_idx = '0;
    mask_idx = '0;
    for (int i = N - 1; i >= 0; i--) begin
      if (match_vec[i]) hit_idx = IDX_W'(i);
      if (free_vec[i])  free_idx = IDX_W'(i);
      if (mask_q[i])    mask_idx = IDX_W'(i);
    end
  end

  // Slot update enables
  always_comb begin
    inc_oh  = '0;
    dec_oh  = '0;
    load_oh = '0;
    if (cmd_i.commit && act_q == ACT_ACQUIRE) begin
      if (hit) begin
        inc_oh = hit_oh;
      end else if (free_any) begin
        load_oh = free_oh;
      end
    end
    if (cmd_i.commit && act_q == ACT_RELEASE && hit) begin
      dec_oh = hit_oh;
    end
    if (cmd_i.evict) begin
      load_oh = mask_oh;
    end
  end

  // Valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      valid_q <= valid_q | load_oh;
    end
  end

  // Tag, count and stamp of each slot
  always_ff @(posedge clk_i) begin
    for (int i = 0; i < N; i++) begin
      if (load_oh[i]) begin
        type_q[i]  <= tag_q;
        refs_q[i]  <= REFS_W'(1);
        stamp_q[i] <= frame_q;
      end else if (inc_oh[i]) begin
        if (refs_q[i] != '1) refs_q[i] <= refs_q[i] + REFS_W'(1);
      end else if (dec_oh[i]) begin
        if (refs_q[i] != '0) begin
          refs_q[i] <= refs_q[i] - REFS_W'(1);
          // stamp on the last release
          if (refs_q[i] == REFS_W'(1)) stamp_q[i] <= frame_q;
        end
      end
    end
  end

  // Frame counter
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frame_q <= '0;
    end else if (cmd_i.commit && act_q == ACT_TICK) begin
      frame_q <= frame_q + AGE_W'(1);
    end
  end

  // Age search: keep the candidates whose age has the current bit set, if any does
  always_ff @(posedge clk_i) begin
    if (cmd_i.scan_init) begin
      mask_q <= idle_vec;
    end else if (cmd_i.scan_step && (|narrow_vec)) begin
      mask_q <= narrow_vec;
    end
  end

  // Result selection
  always_comb begin
    res_we  = cmd_i.commit || cmd_i.evict;
    res_ok  = 1'b0;
    res_up  = 1'b0;
    res_idx = '0;
    if (cmd_i.evict) begin
      res_ok  = 1'b1;
      res_up  = 1'b1;
      res_idx = mask_idx;
    end else begin
      case (act_q) inside
        ACT_ACQUIRE: begin
          if (hit) begin
            res_ok  = 1'b1;
            res_idx = hit_idx;
          end else if (free_any) begin
            res_ok  = 1'b1;
            res_up  = 1'b1;
            res_idx = free_idx;
          end
        end
        ACT_RELEASE, ACT_LOOKUP: begin
          res_ok  = hit;
          res_idx = hit ? hit_idx : '0;
        end
        default: begin
          res_ok = 1'b0;
        end
      endcase
    end
  end

  assign out_free = !out_valid_q || !out_stall_i;

  // Output valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_we) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  // Output payload
  always_ff @(posedge clk_i) begin
    if (res_we) begin
      slot_q <= SLOT_W'(res_idx);
      ok_q   <= res_ok;
      up_q   <= res_up;
      for (int c = 0; c < NCOLORS; c++) begin
        ucol_q[c] <= res_up ? col_q[c] : '0;
      end
    end
  end

  assign status_o.need_scan = (act_q == ACT_ACQUIRE) && !hit && !free_any;
  assign status_o.idle_any  = |idle_vec;
  assign status_o.out_free  = out_free;

  assign out_valid_o = out_valid_q;
  assign slot_o      = slot_q;
  assign slot_ok_o   = ok_q;
  assign upload_o    = up_q;
  assign up_color0_o = ucol_q[0];
  assign up_color1_o = ucol_q[1];
  assign up_color2_o = ucol_q[2];
  assign up_color3_o = ucol_q[3];

endmodule

/* rtl/core/palette_slot_lru_manager.sv */
// Palette slot manager: keeps SLOT_COUNT reference-counted palette slots and
// serves tick, acquire, release and lookup transactions, one result each.
// Tick, lookup, release, an acquire that hits and an acquire that finds a free
// slot are accepted, then done in one evaluation over all slots in parallel.
// An acquire that must evict goes through evaluation, an 8-step search over
// the 8-bit ages of idle slots one bit per cycle (greatest age, lowest index
// on ties), and the load. A result waits in the output register while the next
// transaction is accepted; evaluation and the load hold only while it is
// full and stalled. The slot output carries the low 4 bits of the slot index.
module palette_slot_lru_manager #(
  parameter int SLOT_COUNT = plsm_pkg::SLOT_COUNT_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [1:0]                    action_i,
  input  logic [plsm_pkg::TAG_W-1:0]    type_id_i,
  input  logic [plsm_pkg::COLOR_W-1:0]  in_color0_i,
  input  logic [plsm_pkg::COLOR_W-1:0]  in_color1_i,
  input  logic [plsm_pkg::COLOR_W-1:0]  in_color2_i,
  input  logic [plsm_pkg::COLOR_W-1:0]  in_color3_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [plsm_pkg::SLOT_W-1:0]   slot_o,
  output logic                          slot_ok_o,
  output logic                          upload_o,
  output logic [plsm_pkg::COLOR_W-1:0]  up_color0_o,
  output logic [plsm_pkg::COLOR_W-1:0]  up_color1_o,
  output logic [plsm_pkg::COLOR_W-1:0]  up_color2_o,
  output logic [plsm_pkg::COLOR_W-1:0]  up_color3_o
);
  import plsm_pkg::*;

  dp_cmd_t    cmd;
  dp_status_t status;

  // Sequencer
  plsm_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  // Slot cells, age search and result register
  plsm_dp #(
    .SLOT_COUNT (SLOT_COUNT)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .status_o    (status),
    .action_i    (action_i),
    .type_id_i   (type_id_i),
    .in_color0_i (in_color0_i),
    .in_color1_i (in_color1_i),
    .in_color2_i (in_color2_i),
    .in_color3_i (in_color3_i),
    .out_stall_i (out_stall_i),
    .out_valid_o (out_valid_o),
    .slot_o      (slot_o),
    .slot_ok_o   (slot_ok_o),
    .upload_o    (upload_o),
    .up_color0_o (up_color0_o),
    .up_color1_o (up_color1_o),
    .up_color2_o (up_color2_o),
    .up_color3_o (up_color3_o)
  );

endmodule
